// ===== hw/rtl/tgd_pkg.sv =====
// Shared types, register indexes and event codes for the touch gesture detector.
// No dependencies; every other file of the block imports this package.
package tgd_pkg;

    localparam int LevelW   = 22;
    localparam int ThreshW  = LevelW + 1;
    localparam int TimeW    = 32;
    localparam int MsW      = 16;
    localparam int CfgIdxW  = 3;

    // Register indexes of the configuration port.
    localparam logic [CfgIdxW-1:0] REG_BASELINE   = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_TAP_MAX    = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_DOUBLE_TAP = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_LONG_PRESS = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_FROZEN     = 3'd4;

    // Reset values of the timing registers.
    localparam logic [MsW-1:0] TAP_MAX_RST    = 16'd350;
    localparam logic [MsW-1:0] DOUBLE_TAP_RST = 16'd400;
    localparam logic [MsW-1:0] LONG_PRESS_RST = 16'd1200;
    localparam logic [MsW-1:0] FROZEN_RST     = 16'd500;

    // Event codes reported with each item.
    localparam logic [1:0] EV_NONE       = 2'd0;
    localparam logic [1:0] EV_PIN        = 2'd1;
    localparam logic [1:0] EV_PRIV_ENTER = 2'd2;
    localparam logic [1:0] EV_PRIV_EXIT  = 2'd3;

    typedef struct packed {
        logic [ThreshW-1:0] threshold;
        logic [MsW-1:0]     tap_len;
        logic [MsW-1:0]     dtap_gap;
        logic [MsW-1:0]     hold_len;
        logic [MsW-1:0]     frozen_limit;
    } t_cfg;

    // Press threshold: baseline + floor(2 * baseline / 5). The quotient comes
    // from a multiply by the 32-bit reciprocal of 5, exact for any 32-bit value.
    function automatic logic [ThreshW-1:0] press_threshold(input logic [LevelW-1:0] base);
        logic [TimeW-1:0]   dbl;
        logic [2*TimeW-1:0] prod;
        logic [ThreshW-1:0] quo;
        dbl  = {{(TimeW-LevelW-1){1'b0}}, base, 1'b0};
        prod = {{TimeW{1'b0}}, dbl} * {{TimeW{1'b0}}, 32'hCCCC_CCCD};
        quo  = prod[34 +: ThreshW];
        press_threshold = {1'b0, base} + quo;
    endfunction

endpackage

// ===== hw/rtl/touch_gesture_detector.sv =====
// Top level of the touch gesture detector: input register, gesture state and
// result register. Depends on tgd_pkg and tgd_cfg.
//
// Usage:
// Each input item is one touch reading (i_raw_level) with its millisecond
// timestamp (i_now_ms); it is taken at a clock edge where i_in_valid is high
// and o_in_stall is low. Every item yields exactly one result item on the
// output channel, taken where o_out_valid is high and i_out_stall is low.
// An item is held in the input register and is then evaluated against the
// gesture state in a single pass into the result register, from which its
// result is taken on the output channel.
// One item per cycle is sustained while the receiver does not stall; the
// rate is set by the single state update per item.
// When the receiver stalls, the result register holds and the input register
// fills, after which o_in_stall rises until the result is taken.
// Configuration is written through i_cfg_we / i_cfg_index / i_cfg_wdata while
// no item is in flight; writing the baseline also forms the press threshold.
// Synchronous reset empties both registers, clears all gesture state and
// loads the default timing values.
module touch_gesture_detector (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [tgd_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  logic [tgd_pkg::LevelW-1:0]    i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [tgd_pkg::LevelW-1:0]    i_raw_level,
    input  logic [tgd_pkg::TimeW-1:0]     i_now_ms,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [1:0]                    o_event_code,
    output logic                          o_flash_request,
    output logic                          o_sensor_restart,
    output logic                          o_privacy_mode,
    output logic                          o_touch_active
);
    import tgd_pkg::*;

    t_cfg cfg;

    tgd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // Input register.
    logic              r_in_valid;
    logic [LevelW-1:0] r_raw;
    logic [TimeW-1:0]  r_now;

    // Gesture state.
    logic              r_held;
    logic              r_long_done;
    logic [TimeW-1:0]  r_press_start;
    logic [TimeW-1:0]  r_last_tap;
    logic [LevelW-1:0] r_prev_level;
    logic [MsW-1:0]    r_repeat;
    logic              r_privacy;

    // Result register.
    logic              r_out_valid;
    logic [1:0]        r_event;
    logic              r_flash;
    logic              r_restart;
    logic              r_priv_out;
    logic              r_touch;

    logic              out_blocked;
    logic              adv;
    logic              accept;

    assign out_blocked = r_out_valid && i_out_stall;
    assign adv         = r_in_valid && !out_blocked;
    assign o_in_stall  = r_in_valid && out_blocked;
    assign accept      = i_in_valid && !o_in_stall;

    // Single-pass evaluation of the item in the input register.
    logic              same_level;
    logic [MsW-1:0]    repeat_inc;
    logic              restart;
    logic [MsW-1:0]    n_repeat;
    logic              pressed;
    logic              press_begin;
    logic [TimeW-1:0]  start_ms;
    logic              long_done_eff;
    logic [TimeW-1:0]  hold_ms;
    logic [TimeW-1:0]  gap_ms;
    logic              long_fire;
    logic              n_privacy;
    logic              tap;
    logic              dbl_tap;
    logic [TimeW-1:0]  n_last_tap;
    logic [1:0]        n_event;
    logic              n_flash;

    always_comb begin
        same_level    = (r_raw == r_prev_level);
        repeat_inc    = r_repeat + MsW'(1);
        restart       = same_level && (repeat_inc >= cfg.frozen_limit);
        n_repeat      = (same_level && !restart) ? repeat_inc : '0;

        pressed       = {1'b0, r_raw} > cfg.threshold;
        press_begin   = pressed && !r_held;
        start_ms      = press_begin ? r_now : r_press_start;
        long_done_eff = press_begin ? 1'b0 : r_long_done;
        hold_ms       = r_now - start_ms;
        gap_ms        = r_now - r_last_tap;

        long_fire     = pressed && !long_done_eff
                        && (hold_ms >= {{(TimeW-MsW){1'b0}}, cfg.hold_len});
        n_privacy     = r_privacy ^ long_fire;

        // A release of a short press that never fired the long press is a tap.
        tap           = !pressed && r_held && !r_long_done
                        && (hold_ms < {{(TimeW-MsW){1'b0}}, cfg.tap_len});
        dbl_tap       = tap && (gap_ms <= {{(TimeW-MsW){1'b0}}, cfg.dtap_gap});

        n_last_tap = r_last_tap;
        if (dbl_tap) begin
            n_last_tap = '0;
        end else if (tap) begin
            n_last_tap = r_now;
        end

        n_event = EV_NONE;
        n_flash = 1'b0;
        if (long_fire) begin
            n_event = n_privacy ? EV_PRIV_ENTER : EV_PRIV_EXIT;
        end else if (dbl_tap && !r_privacy) begin
            n_event = EV_PIN;
            n_flash = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_held        <= 1'b0;
            r_long_done   <= 1'b0;
            r_press_start <= '0;
            r_last_tap    <= '0;
            r_prev_level  <= '0;
            r_repeat      <= '0;
            r_privacy     <= 1'b0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end

            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (adv) begin
                r_held        <= pressed;
                r_long_done   <= long_done_eff | long_fire;
                r_press_start <= start_ms;
                r_last_tap    <= n_last_tap;
                r_prev_level  <= r_raw;
                r_repeat      <= n_repeat;
                r_privacy     <= n_privacy;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_raw <= i_raw_level;
            r_now <= i_now_ms;
        end
        if (adv) begin
            r_event    <= n_event;
            r_flash    <= n_flash;
            r_restart  <= restart;
            r_priv_out <= n_privacy;
            r_touch    <= pressed;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_event_code     = r_event;
    assign o_flash_request  = r_flash;
    assign o_sensor_restart = r_restart;
    assign o_privacy_mode   = r_priv_out;
    assign o_touch_active   = r_touch;

endmodule

// ===== hw/rtl/tgd_cfg.sv =====
// Configuration registers of the touch gesture detector.
// Depends on tgd_pkg; the baseline is stored as its ready-made press threshold.
module tgd_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [tgd_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  logic [tgd_pkg::LevelW-1:0]    i_cfg_wdata,
    output tgd_pkg::t_cfg                 o_cfg
);
    import tgd_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                REG_BASELINE:   n_cfg.threshold    = press_threshold(i_cfg_wdata);
                REG_TAP_MAX:    n_cfg.tap_len      = i_cfg_wdata[MsW-1:0];
                REG_DOUBLE_TAP: n_cfg.dtap_gap     = i_cfg_wdata[MsW-1:0];
                REG_LONG_PRESS: n_cfg.hold_len     = i_cfg_wdata[MsW-1:0];
                REG_FROZEN:     n_cfg.frozen_limit = i_cfg_wdata[MsW-1:0];
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold    <= '0;
            r_cfg.tap_len      <= TAP_MAX_RST;
            r_cfg.dtap_gap     <= DOUBLE_TAP_RST;
            r_cfg.hold_len     <= LONG_PRESS_RST;
            r_cfg.frozen_limit <= FROZEN_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== tb/tb_touch_gesture_detector.sv =====
// Self-checking testbench for touch_gesture_detector: a directed table, then random
// gesture sequences (taps, long presses, frozen runs, noise) under several register settings.
// Depends on tgd_pkg and the detector RTL; results are checked against an in-bench predictor.
`timescale 1ns / 1ps

module tb_touch_gesture_detector;
    import tgd_pkg::*;

    localparam logic [LevelW-1:0] LEVEL_MAX = '1;
    localparam int ITEMS_PER_PHASE = 195;
    localparam int NUM_PHASES = 10;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [1:0] ev;
        logic       flash;
        logic       restart;
        logic       privacy;
        logic       touch;
    } t_gesture_out;

    typedef enum logic {ROW_CFG, ROW_ITEM} t_row_kind;

    typedef struct {
        t_row_kind           kind;
        logic [CfgIdxW-1:0]  idx;
        logic [LevelW-1:0]   val;
        logic [LevelW-1:0]   raw;
        logic [TimeW-1:0]    now;
        bit                  typed;
        t_gesture_out        want;
    } t_plan_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic [CfgIdxW-1:0]  i_cfg_index = '0;
    logic [LevelW-1:0]   i_cfg_wdata = '0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic [LevelW-1:0]   i_raw_level = '0;
    logic [TimeW-1:0]    i_now_ms = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic [1:0]          o_event_code;
    logic                o_flash_request;
    logic                o_sensor_restart;
    logic                o_privacy_mode;
    logic                o_touch_active;

    touch_gesture_detector dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_raw_level      (i_raw_level),
        .i_now_ms         (i_now_ms),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_event_code     (o_event_code),
        .o_flash_request  (o_flash_request),
        .o_sensor_restart (o_sensor_restart),
        .o_privacy_mode   (o_privacy_mode),
        .o_touch_active   (o_touch_active)
    );

    always #6 i_clk = ~i_clk;

    // Gesture predictor: register copies and state.
    logic [LevelW-1:0] base_level = '0;
    logic [MsW-1:0]    tap_limit = TAP_MAX_RST;
    logic [MsW-1:0]    dtap_window = DOUBLE_TAP_RST;
    logic [MsW-1:0]    hold_limit = LONG_PRESS_RST;
    logic [MsW-1:0]    freeze_limit = FROZEN_RST;
    logic              pad_held = 1'b0;
    logic              long_fired = 1'b0;
    logic [TimeW-1:0]  press_t0 = '0;
    logic [TimeW-1:0]  tap_t0 = '0;
    logic [LevelW-1:0] last_level = '0;
    logic [MsW-1:0]    same_count = '0;
    logic              privacy = 1'b0;

    t_gesture_out pending_results[$];
    t_plan_row    plan[$];
    int           mismatches = 0;
    int           quiet_cycles = 0;
    int           items_done = 0;
    bit           idle_on = 1'b1;
    logic [TimeW-1:0] t_now = '0;

    function automatic logic [ThreshW-1:0] press_limit();
        logic [24:0] b;
        b = {3'b000, base_level};
        return ThreshW'(b + (b * 2) / 5);
    endfunction

    function automatic t_gesture_out predict_gesture(input logic [LevelW-1:0] raw,
                                                     input logic [TimeW-1:0] now);
        t_gesture_out r;
        logic pressed;
        r = '0;
        if (raw == last_level) begin
            same_count = same_count + 16'd1;
            if (same_count >= freeze_limit) begin
                same_count = '0;
                r.restart = 1'b1;
            end
        end else begin
            last_level = raw;
            same_count = '0;
        end
        pressed = {1'b0, raw} > press_limit();
        if (pressed && !pad_held) begin
            pad_held = 1'b1;
            long_fired = 1'b0;
            press_t0 = now;
        end
        if (pressed && pad_held && !long_fired && (now - press_t0) >= {16'd0, hold_limit}) begin
            long_fired = 1'b1;
            privacy = !privacy;
            r.ev = privacy ? EV_PRIV_ENTER : EV_PRIV_EXIT;
        end
        if (!pressed && pad_held) begin
            pad_held = 1'b0;
            if (!long_fired && (now - press_t0) < {16'd0, tap_limit}) begin
                // Second tap inside the window: the tap history is consumed either way.
                if ((now - tap_t0) <= {16'd0, dtap_window}) begin
                    tap_t0 = '0;
                    if (!privacy) begin
                        r.ev = EV_PIN;
                        r.flash = 1'b1;
                    end
                end else begin
                    tap_t0 = now;
                end
            end
        end
        r.privacy = privacy;
        r.touch = pressed;
        return r;
    endfunction

    always @(negedge i_clk) begin
        i_out_stall <= idle_on && ($urandom_range(99) < 38);
    end

    always @(posedge i_clk) begin : result_check
        t_gesture_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result item arrived with no expectation waiting");
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (o_event_code !== want.ev) begin
                    $error("event_code: expected %0d, actual %0d", want.ev, o_event_code);
                    mismatches++;
                end
                if (o_flash_request !== want.flash) begin
                    $error("flash_request: expected %0d, actual %0d", want.flash, o_flash_request);
                    mismatches++;
                end
                if (o_sensor_restart !== want.restart) begin
                    $error("sensor_restart: expected %0d, actual %0d",
                           want.restart, o_sensor_restart);
                    mismatches++;
                end
                if (o_privacy_mode !== want.privacy) begin
                    $error("privacy_mode: expected %0d, actual %0d", want.privacy, o_privacy_mode);
                    mismatches++;
                end
                if (o_touch_active !== want.touch) begin
                    $error("touch_active: expected %0d, actual %0d", want.touch, o_touch_active);
                    mismatches++;
                end
            end
        end
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_reading(input logic [LevelW-1:0] raw, input logic [TimeW-1:0] now,
                                input bit typed, input t_gesture_out want);
        t_gesture_out predicted;
        while (idle_on && $urandom_range(99) < 38) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_raw_level <= raw;
        i_now_ms <= now;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predicted = predict_gesture(raw, now);
        pending_results.push_back(typed ? want : predicted);
        items_done++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [LevelW-1:0] val);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        case (idx)
            REG_BASELINE:   base_level = val;
            REG_TAP_MAX:    tap_limit = val[MsW-1:0];
            REG_DOUBLE_TAP: dtap_window = val[MsW-1:0];
            REG_LONG_PRESS: hold_limit = val[MsW-1:0];
            REG_FROZEN:     freeze_limit = val[MsW-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic add_cfg(input logic [CfgIdxW-1:0] idx, input logic [LevelW-1:0] val);
        t_plan_row row;
        row = '{ROW_CFG, idx, val, '0, '0, 1'b0, '0};
        plan.push_back(row);
    endtask

    task automatic add_item(input logic [LevelW-1:0] raw, input logic [TimeW-1:0] now);
        t_plan_row row;
        row = '{ROW_ITEM, '0, '0, raw, now, 1'b0, '0};
        plan.push_back(row);
    endtask

    task automatic add_typed(input logic [LevelW-1:0] raw, input logic [TimeW-1:0] now,
                             input t_gesture_out want);
        t_plan_row row;
        row = '{ROW_ITEM, '0, '0, raw, now, 1'b1, want};
        plan.push_back(row);
    endtask

    function automatic logic [LevelW-1:0] pressed_level();
        logic [ThreshW-1:0] thr;
        thr = press_limit();
        // A baseline near the top leaves no reading that counts as pressed.
        if (thr >= {1'b0, LEVEL_MAX}) return LevelW'($urandom);
        return LevelW'($urandom_range(LEVEL_MAX, thr + 1));
    endfunction

    function automatic logic [LevelW-1:0] unpressed_level();
        logic [ThreshW-1:0] thr;
        thr = press_limit();
        if (thr > {1'b0, LEVEL_MAX}) thr = {1'b0, LEVEL_MAX};
        return LevelW'($urandom_range(thr, 0));
    endfunction

    function automatic int unsigned near(input int unsigned x);
        case ($urandom_range(4))
            0: return (x == 0) ? 0 : x - 1;
            1: return x;
            2: return x + 1;
            default: return $urandom_range(2 * x + 20, 0);
        endcase
    endfunction

    task automatic play_gesture();
        int unsigned kind;
        int unsigned hold;
        int unsigned reps;
        logic [LevelW-1:0] lvl;
        kind = $urandom_range(9);
        if (kind <= 3) begin
            hold = near(32'(tap_limit));
            send_reading(pressed_level(), t_now, 1'b0, '0);
            if (hold > 1 && $urandom_range(1)) begin
                send_reading(pressed_level(), t_now + hold / 2, 1'b0, '0);
            end
            t_now += hold;
            send_reading(unpressed_level(), t_now, 1'b0, '0);
            t_now += near(32'(dtap_window));
        end else if (kind <= 5) begin
            hold = near(32'(hold_limit));
            lvl = pressed_level();
            send_reading(lvl, t_now, 1'b0, '0);
            send_reading(lvl, t_now + hold / 2, 1'b0, '0);
            t_now += hold;
            send_reading(pressed_level(), t_now, 1'b0, '0);
            t_now += $urandom_range(50);
            send_reading(unpressed_level(), t_now, 1'b0, '0);
            t_now += near(32'(dtap_window));
        end else if (kind <= 7) begin
            lvl = $urandom_range(1) ? pressed_level() : unpressed_level();
            reps = (freeze_limit <= 30) ? freeze_limit + $urandom_range(2)
                                        : $urandom_range(30, 1);
            repeat (reps + 1) begin
                send_reading(lvl, t_now, 1'b0, '0);
                t_now += $urandom_range(20);
            end
        end else begin
            send_reading(LevelW'($urandom), $urandom_range(1) ? $urandom
                                                             : t_now + $urandom_range(10),
                         1'b0, '0);
        end
    endtask

    task automatic set_phase(input int p);
        logic [LevelW-1:0] base;
        logic [MsW-1:0] ms[3];
        logic [MsW-1:0] frz;
        if (p == 0) begin
            base = LEVEL_MAX;
            ms = '{16'hFFFF, 16'hFFFF, 16'hFFFF};
            frz = 16'hFFFF;
        end else if (p == 1) begin
            base = '0;
            ms = '{16'd0, 16'd0, 16'd0};
            frz = 16'd1;
        end else begin
            case ($urandom_range(3))
                0: base = '0;
                1: base = LevelW'($urandom_range(40));
                2: base = LevelW'($urandom);
                default: base = LEVEL_MAX - LevelW'($urandom_range(3));
            endcase
            foreach (ms[k]) begin
                case ($urandom_range(5))
                    0: ms[k] = 16'd0;
                    1: ms[k] = 16'hFFFF;
                    2: ms[k] = MsW'($urandom);
                    default: ms[k] = MsW'($urandom_range(600, 1));
                endcase
            end
            case ($urandom_range(3))
                0: frz = 16'd1;
                1: frz = 16'hFFFF;
                default: frz = MsW'($urandom_range(12, 2));
            endcase
        end
        write_reg(REG_BASELINE, base);
        write_reg(REG_TAP_MAX, {6'd0, ms[0]});
        write_reg(REG_DOUBLE_TAP, {6'd0, ms[1]});
        write_reg(REG_LONG_PRESS, {6'd0, ms[2]});
        write_reg(REG_FROZEN, {6'd0, frz});
        t_now = ($urandom_range(3) == 0) ? 32'hFFFF_F000 + $urandom_range(4000) : $urandom;
    endtask

    initial begin
        int target;
        bit paused;
        // Default registers: any nonzero reading is a press.
        add_typed(22'd0, 32'd0, '{EV_NONE, 1'b0, 1'b0, 1'b0, 1'b0});
        add_item(LEVEL_MAX, 32'd100);
        // First tap after reset pairs with the implicit tap at time zero.
        add_typed(22'd0, 32'd200, '{EV_PIN, 1'b1, 1'b0, 1'b0, 1'b0});
        add_cfg(REG_FROZEN, 22'd1);
        add_typed(22'd0, 32'd300, '{EV_NONE, 1'b0, 1'b1, 1'b0, 1'b0});
        add_cfg(REG_FROZEN, 22'd0);
        add_item(22'd0, 32'd310);
        add_cfg(REG_FROZEN, 22'd2);
        add_cfg(REG_BASELINE, 22'd5);
        // Threshold is 7: equal is not pressed, one above is.
        add_item(22'd7, 32'd400);
        add_item(22'd8, 32'd500);
        add_item(22'd8, 32'd1700);
        add_item(22'd8, 32'd1800);
        add_item(22'd0, 32'd1900);
        // Two taps while privacy is on: the pin event is suppressed.
        add_item(22'd8, 32'd2000);
        add_item(22'd0, 32'd2100);
        add_item(22'd8, 32'd2200);
        add_item(22'd0, 32'd2300);
        add_cfg(REG_LONG_PRESS, 22'd0);
        add_item(22'd9, 32'd2400);
        add_cfg(REG_TAP_MAX, 22'd0);
        add_cfg(REG_LONG_PRESS, 22'd65535);
        add_cfg(REG_DOUBLE_TAP, 22'd65535);
        add_item(22'd9, 32'd2500);
        add_item(22'd0, 32'd2510);
        add_item(22'd9, 32'd2600);
        add_item(22'd0, 32'd2601);
        add_cfg(REG_TAP_MAX, 22'd65535);
        // Press and release straddle the timestamp wrap.
        add_item(22'd9, 32'hFFFF_FFF0);
        add_item(22'd0, 32'h0000_0010);
        add_cfg(REG_BASELINE, LEVEL_MAX);
        add_item(LEVEL_MAX, 32'hFFFF_FFFF);
        add_item(22'd1, 32'd0);

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG) begin
                write_reg(plan[i].idx, plan[i].val);
            end else begin
                send_reading(plan[i].raw, plan[i].now, plan[i].typed, plan[i].want);
            end
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            set_phase(p);
            idle_on = (p != 4);
            target = items_done + ITEMS_PER_PHASE;
            paused = 1'b0;
            while (items_done < target) begin
                if (p == 5 && !paused && items_done >= target - ITEMS_PER_PHASE / 2) begin
                    drain();
                    paused = 1'b1;
                end
                play_gesture();
            end
        end
        idle_on = 1'b1;

        drain();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== touch_gesture_detector.f =====
hw/rtl/tgd_pkg.sv
hw/rtl/tgd_cfg.sv
hw/rtl/touch_gesture_detector.sv
tb/tb_touch_gesture_detector.sv
